// File: rtl/core/sbt_pkg.sv
// sbt_pkg: shared types and constants for the socket binding table
// no dependencies
package sbt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 7;
  localparam logic [15:0] SOCKET_MAX   = 16'd65535;
  localparam logic [15:0] DEFAULT_BASE = 16'd1024;
  localparam logic [15:0] DEFAULT_TMO  = 16'd30;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_BASE    = 2'd1;

  typedef enum logic [2:0] {
    OP_CHECK   = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_ADD     = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_REFRESH = 3'd4,
    OP_EXPIRE  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CONFLICT  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_SOCKET = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_MV_RD,
    S_MV_WR
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] socket_number;
    logic [31:0] net_number;
    logic [47:0] node_number;
    logic [15:0] owner_port;
    logic        reuse_flag;
    logic [31:0] now_seconds;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      allocated_socket;
    logic [CNT_W-1:0] entry_total;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] wdata;
  } cfg_beat_t;

  typedef struct packed {
    logic [31:0] net;
    logic [47:0] node;
    logic [15:0] socket;
    logic        reuse;
    logic [15:0] owner;
    logic [31:0] seen;
  } entry_t;

endpackage

// File: rtl/core/sbt_if.sv
// sbt_if: valid/ready channel interfaces for input, result and config beats
// depends on sbt_pkg
interface sbt_in_if;
  logic             valid;
  logic             ready;
  sbt_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sbt_out_if;
  logic               valid;
  logic               ready;
  sbt_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sbt_cfg_if;
  logic               valid;
  logic               ready;
  sbt_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/socket_binding_table.sv
// socket_binding_table: binding table with sequenced scan over one memory port
// depends on sbt_pkg and sbt_if
//
// channel   dir  beat
// in_ch     in   opcode, socket, net, node, owner port, reuse, time
// out_ch    out  status, allocated socket, entry total
// cfg_ch    in   register index, write data
//
// add, unused opcodes and ops on an empty table finish from idle; others visit
// entries via read and evaluate states (registered memory read), plus move-read
// and move-write states per moved entry; allocate restarts at entry 0 after each hit
// in_ch ready only when idle and the result register is empty
// synchronous active-low reset clears control and config; memory is not cleared
module socket_binding_table (
  input  logic         clk,
  input  logic         rst_n,
  sbt_in_if.sink       in_ch,
  sbt_out_if.source    out_ch,
  sbt_cfg_if.sink      cfg_ch
);

  localparam int IW = sbt_pkg::IDX_W;
  localparam int CW = sbt_pkg::CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(sbt_pkg::TABLE_DEPTH);

  sbt_pkg::entry_t mem [sbt_pkg::TABLE_DEPTH];

  sbt_pkg::state_t   state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [15:0]       cand_r, cand_nxt;
  sbt_pkg::in_beat_t req_r, req_nxt;
  sbt_pkg::entry_t   rdata_r;
  logic [15:0]       tmo_r, base_r;
  logic              out_valid_r;
  sbt_pkg::out_beat_t out_r;

  logic              rd_en, wr_en, fin;
  logic [IW-1:0]     rd_addr, wr_addr;
  sbt_pkg::entry_t   wr_data, ent;
  sbt_pkg::status_t  fst;
  logic [15:0]       falloc;
  logic              accept, last, expired;
  logic [CW-1:0]     cnt_m1;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == sbt_pkg::S_IDLE) && !out_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  assign ent = rdata_r;
  assign cnt_m1 = cnt_r - CW'(1);
  assign last = ({1'b0, idx_r} + CW'(1)) == cnt_r;
  assign expired = ({1'b0, ent.seen} + {17'b0, tmo_r}) <= {1'b0, req_r.now_seconds};

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    cand_nxt  = cand_r;
    req_nxt   = req_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rdata_r;
    fin       = 1'b0;
    fst       = sbt_pkg::ST_OK;
    falloc    = 16'd0;
    unique case (state_r)
      sbt_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt  = in_ch.data;
          idx_nxt  = '0;
          cand_nxt = (base_r == 16'd0) ? 16'd1 : base_r;
          case (in_ch.data.opcode)
            sbt_pkg::OP_CHECK, sbt_pkg::OP_EXPIRE: begin
              if (cnt_r == '0) fin = 1'b1;
              else state_nxt = sbt_pkg::S_RD;
            end
            sbt_pkg::OP_ALLOC: begin
              if (cnt_r == '0) begin
                fin = 1'b1;
                falloc = (base_r == 16'd0) ? 16'd1 : base_r;
              end else state_nxt = sbt_pkg::S_RD;
            end
            sbt_pkg::OP_REMOVE, sbt_pkg::OP_REFRESH: begin
              if (cnt_r == '0) begin
                fin = 1'b1;
                fst = sbt_pkg::ST_NOT_FOUND;
              end else state_nxt = sbt_pkg::S_RD;
            end
            sbt_pkg::OP_ADD: begin
              fin = 1'b1;
              if (cnt_r < DEPTH_C) begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[IW-1:0];
                wr_data = '{net: in_ch.data.net_number, node: in_ch.data.node_number,
                            socket: in_ch.data.socket_number,
                            reuse: in_ch.data.reuse_flag,
                            owner: in_ch.data.owner_port, seen: in_ch.data.now_seconds};
                cnt_nxt = cnt_r + CW'(1);
              end else fst = sbt_pkg::ST_FULL;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      sbt_pkg::S_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = sbt_pkg::S_EV;
      end
      sbt_pkg::S_EV: begin
        state_nxt = sbt_pkg::S_RD;
        idx_nxt   = idx_r + IW'(1);
        case (req_r.opcode)
          sbt_pkg::OP_CHECK: begin
            if (ent.socket == req_r.socket_number && (!ent.reuse || !req_r.reuse_flag)) begin
              fin = 1'b1;
              fst = sbt_pkg::ST_CONFLICT;
            end else if (last) fin = 1'b1;
          end
          sbt_pkg::OP_ALLOC: begin
            if (ent.socket == cand_r) begin
              if (cand_r == sbt_pkg::SOCKET_MAX) begin
                fin = 1'b1;
                fst = sbt_pkg::ST_NO_SOCKET;
              end else begin
                cand_nxt = cand_r + 16'd1;
                idx_nxt  = '0;
              end
            end else if (last) begin
              fin    = 1'b1;
              falloc = cand_r;
            end
          end
          sbt_pkg::OP_REMOVE: begin
            if (ent.owner == req_r.owner_port) begin
              idx_nxt   = idx_r;
              state_nxt = sbt_pkg::S_MV_RD;
            end else if (last) begin
              fin = 1'b1;
              fst = sbt_pkg::ST_NOT_FOUND;
            end
          end
          sbt_pkg::OP_REFRESH: begin
            if (ent.owner == req_r.owner_port) begin
              wr_en   = 1'b1;
              wr_addr = idx_r;
              wr_data = ent;
              wr_data.seen = req_r.now_seconds;
              fin = 1'b1;
            end else if (last) begin
              fin = 1'b1;
              fst = sbt_pkg::ST_NOT_FOUND;
            end
          end
          sbt_pkg::OP_EXPIRE: begin
            if (expired) begin
              idx_nxt   = idx_r;
              state_nxt = sbt_pkg::S_MV_RD;
            end else if (last) fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end
      sbt_pkg::S_MV_RD: begin
        rd_en     = 1'b1;
        rd_addr   = cnt_m1[IW-1:0];
        state_nxt = sbt_pkg::S_MV_WR;
      end
      sbt_pkg::S_MV_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rdata_r;
        cnt_nxt = cnt_m1;
        if (req_r.opcode == sbt_pkg::OP_REMOVE || last) fin = 1'b1;
        else state_nxt = sbt_pkg::S_RD;
      end
      default: state_nxt = sbt_pkg::S_IDLE;
    endcase
    if (fin) state_nxt = sbt_pkg::S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      tmo_r       <= sbt_pkg::DEFAULT_TMO;
      base_r      <= sbt_pkg::DEFAULT_BASE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (fin) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_ch.valid) begin
        if (cfg_ch.data.index == sbt_pkg::CFG_TIMEOUT) tmo_r <= cfg_ch.data.wdata;
        if (cfg_ch.data.index == sbt_pkg::CFG_BASE) base_r <= cfg_ch.data.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cand_r <= cand_nxt;
    req_r  <= req_nxt;
    if (fin) begin
      out_r.status           <= fst;
      out_r.allocated_socket <= falloc;
      out_r.entry_total      <= cnt_nxt;
    end
  end

  // table memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("entry count above depth");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> state_r == sbt_pkg::S_IDLE && out_valid_r) else $error("finish did not post result");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en)) else $error("read and write in same cycle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !out_valid_r && state_r == sbt_pkg::S_IDLE) else $error("accept while busy");

endmodule
